### sv/itra_pkg.sv
`timescale 1ns / 1ps
// Shared constants, payload types and helper functions for the radix text converter.
// Depends on nothing; the other files but itra_ram refer to it by scoped names.
package itra_pkg;

    localparam int VALUE_W    = 32;
    localparam int MAX_DIGITS = 32;
    localparam int DIGIT_W    = 6;
    localparam int CHAR_W     = 7;
    localparam int LEN_W      = 6;
    localparam int RADIX_W    = 6;
    localparam int ADDR_W     = $clog2(MAX_DIGITS);
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int BIT_CNT_W  = $clog2(VALUE_W);

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] RADIX_DEC   = RADIX_W'(10);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
        logic [LEN_W-1:0]  text_length;
    } text_item_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture the accepted value
        logic div_start;  // start one division of the running quotient
        logic store;      // write the remainder digit and take the quotient
        logic sign_emit;  // load a minus sign into the output register
        logic emit;       // load the digit read from the store
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_done;
        logic more_digits;
        logic neg;
        logic slot_free;
        logic emit_last;
    } status_t;

    // Clamp the configured radix into 2..36
    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN)
            res = RADIX_MIN;
        else if (r > RADIX_MAX)
            res = RADIX_MAX;
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] res;
        if (d < DIGIT_W'(10))
            res = CHAR_ZERO + CHAR_W'(d);
        else
            res = CHAR_A + CHAR_W'(d) - CHAR_W'(10);
        return res;
    endfunction

endpackage

### sv/itra_if.sv
`timescale 1ns / 1ps
// Handshake channels of the radix text converter: value in, text out, radix write.
// Depends on itra_pkg for payload widths.
interface itra_value_if;
    logic                 valid;
    logic                 ready;
    itra_pkg::value_t     value;
    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface itra_text_if;
    logic                          valid;
    logic                          ready;
    logic [itra_pkg::CHAR_W-1:0]   character;
    logic                          last;
    logic [itra_pkg::LEN_W-1:0]    text_length;
    modport source (output valid, output character, output last, output text_length,
                    input ready);
    modport sink   (input valid, input character, input last, input text_length,
                    output ready);
endinterface

interface itra_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [itra_pkg::RADIX_W-1:0]  radix;
    modport source (output valid, output radix, input ready);
    modport sink   (input valid, input radix, output ready);
endinterface

### sv/itra_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module itra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

### sv/itra_div.sv
`timescale 1ns / 1ps
// Restoring divider: value by radix, one quotient bit per cycle.
// Depends on itra_pkg.
module itra_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [itra_pkg::VALUE_W-1:0]  dividend,
    input  logic [itra_pkg::RADIX_W-1:0]  divisor,
    output logic                          done,
    output logic [itra_pkg::VALUE_W-1:0]  quotient,
    output logic [itra_pkg::DIGIT_W-1:0]  remainder
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [itra_pkg::BIT_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [itra_pkg::VALUE_W-1:0]    q_reg, q_next;
    logic [itra_pkg::DIGIT_W-1:0]    r_reg, r_next;
    logic [itra_pkg::RADIX_W-1:0]    d_reg, d_next;
    logic [itra_pkg::DIGIT_W:0]      trial;

    assign trial = {r_reg, q_reg[itra_pkg::VALUE_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = itra_pkg::DIGIT_W'(trial - {1'b0, d_reg});
                q_next = {q_reg[itra_pkg::VALUE_W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[itra_pkg::DIGIT_W-1:0];
                q_next = {q_reg[itra_pkg::VALUE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == itra_pkg::BIT_CNT_W'(itra_pkg::VALUE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

### sv/itra_datapath.sv
`timescale 1ns / 1ps
// Datapath: radix register, running quotient, digit store, divider and output register.
// Depends on itra_pkg, itra_ram and itra_div.
module itra_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  itra_pkg::cmd_t                cmd,
    output itra_pkg::status_t             sts,
    input  itra_pkg::value_t              value,
    input  logic                          cfg_we,
    input  logic [itra_pkg::RADIX_W-1:0]  cfg_radix,
    input  logic                          out_ready,
    output logic                          out_valid,
    output itra_pkg::text_item_t          out_item
);

    logic [itra_pkg::RADIX_W-1:0]  radix_reg;
    logic [itra_pkg::RADIX_W-1:0]  base;
    logic [itra_pkg::VALUE_W-1:0]  quot_reg;
    logic [itra_pkg::CNT_W-1:0]    count_reg;
    logic [itra_pkg::CNT_W-1:0]    emit_cnt_reg;
    logic [itra_pkg::CNT_W-1:0]    count_inc;
    logic                          neg_reg;
    logic                          value_neg;
    logic                          out_valid_reg;
    itra_pkg::text_item_t          out_reg, out_next;
    logic                          div_done;
    logic [itra_pkg::VALUE_W-1:0]  div_q;
    logic [itra_pkg::DIGIT_W-1:0]  div_r;
    logic [itra_pkg::DIGIT_W-1:0]  ram_rdata;
    logic [itra_pkg::ADDR_W-1:0]   ram_raddr;
    logic                          emit_last;

    assign base      = itra_pkg::clamp_radix(radix_reg);
    assign value_neg = (base == itra_pkg::RADIX_DEC) && value[itra_pkg::VALUE_W-1];
    assign count_inc = count_reg + 1'b1;
    assign emit_last = (emit_cnt_reg == itra_pkg::CNT_W'(1));
    assign ram_raddr = itra_pkg::ADDR_W'(emit_cnt_reg - 1'b1);

    itra_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (quot_reg),
        .divisor   (base),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    itra_ram #(
        .WIDTH (itra_pkg::DIGIT_W),
        .DEPTH (itra_pkg::MAX_DIGITS)
    ) u_store (
        .clk   (clk),
        .we    (cmd.store),
        .waddr (count_reg[itra_pkg::ADDR_W-1:0]),
        .wdata (div_r),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_reg <= itra_pkg::RADIX_RESET;
        else if (cfg_we)
            radix_reg <= cfg_radix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quot_reg     <= '0;
            count_reg    <= '0;
            emit_cnt_reg <= '0;
            neg_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                neg_reg      <= value_neg;
                quot_reg     <= value_neg ? (~value + 1'b1) : value;
                count_reg    <= '0;
                emit_cnt_reg <= '0;
            end
            else if (cmd.store)
            begin
                quot_reg     <= div_q;
                count_reg    <= count_inc;
                emit_cnt_reg <= count_inc;
            end
            else if (cmd.emit)
                emit_cnt_reg <= emit_cnt_reg - 1'b1;
        end
    end

    always_comb
    begin
        out_next = out_reg;
        if (cmd.sign_emit)
        begin
            out_next.character   = itra_pkg::CHAR_MINUS;
            out_next.last        = 1'b0;
            out_next.text_length = '0;
        end
        else if (cmd.emit)
        begin
            out_next.character   = itra_pkg::digit_char(ram_rdata);
            out_next.last        = emit_last;
            out_next.text_length = emit_last
                ? itra_pkg::LEN_W'(count_reg) + itra_pkg::LEN_W'(neg_reg) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.sign_emit || cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign sts.div_done    = div_done;
    assign sts.more_digits = (div_q != '0) &&
                             (count_inc < itra_pkg::CNT_W'(itra_pkg::MAX_DIGITS));
    assign sts.neg         = neg_reg;
    assign sts.slot_free   = !out_valid_reg || out_ready;
    assign sts.emit_last   = emit_last;

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

### sv/itra_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences load, digit divisions and reversed emission.
// Depends on itra_pkg.
module itra_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  itra_pkg::status_t  sts,
    output itra_pkg::cmd_t     cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_START  = 6'b000010,
        ST_DIVIDE = 6'b000100,
        ST_SIGN   = 6'b001000,
        ST_READ   = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (sts.div_done)
                begin
                    cmd.store = 1'b1;
                    priority if (sts.more_digits)
                        state_next = ST_START;
                    else if (sts.neg)
                        state_next = ST_SIGN;
                    else
                        state_next = ST_READ;
                end
            end
            ST_SIGN:
            begin
                if (sts.slot_free)
                begin
                    cmd.sign_emit = 1'b1;
                    state_next    = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sts.emit_last ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### sv/integer_to_radix_ascii_core.sv
`timescale 1ns / 1ps
// Top level of the integer to radix text converter: controller plus datapath.
// Depends on itra_pkg, itra_if, itra_ctrl and itra_datapath.
//
//  channel  | dir | payload                          | request moves
//  ---------+-----+----------------------------------+------------------------------
//  number   | in  | value (32 b signed)              | one integer to convert
//  text     | out | character (7), last, text_length | one ASCII character, MSD first
//  cfg      | in  | radix (6 b)                      | one radix write, reset 10
//
// Sequence: per digit, a start state, a division by the one-bit-per-cycle
// divider and a store state; then a minus sign if any, and per digit character
// a digit store read and an output load. Output stalls hold the emission.
// Reset clears the controller, the running quotient, the counters, the output
// valid and sets the radix to ten. A stalled text request holds the output
// register and the controller waits; number is taken only while idle.
module integer_to_radix_ascii_core (
    input  logic   clk,
    input  logic   rst_n,
    itra_value_if.sink   number,
    itra_text_if.source  text,
    itra_cfg_if.sink     cfg
);

    itra_pkg::cmd_t        cmd;
    itra_pkg::status_t     sts;
    itra_pkg::text_item_t  out_item;
    logic                  out_valid;

    // The radix register takes a write at any time; write it only between conversions.
    assign cfg.ready = 1'b1;

    // Sequence the conversion: one request in flight at a time.
    itra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (number.valid),
        .in_ready (number.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Divide, store digits least significant first, then drain them in reverse.
    itra_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .value     (number.value),
        .cfg_we    (cfg.valid && cfg.ready),
        .cfg_radix (cfg.radix),
        .out_ready (text.ready),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

    assign text.valid       = out_valid;
    assign text.character   = out_item.character;
    assign text.last        = out_item.last;
    assign text.text_length = out_item.text_length;

endmodule

### sv/itra_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the radix text converter, bound to the top level.
// Depends on itra_pkg and integer_to_radix_ascii_core.
module itra_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [itra_pkg::CHAR_W-1:0]   character,
    input  logic                          last,
    input  logic [itra_pkg::LEN_W-1:0]    text_length
);

    // One conversion at a time: no second request straight after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted twice in a row");

    // A stalled character holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(character) &&
                                      $stable(last) && $stable(text_length)))
        else $error("stalled character changed");

    a_len_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (text_length != '0))
        else $error("final character without a length");

    a_len_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (text_length == '0))
        else $error("length shown before the final character");

    // A minus sign, which leads the text, never ends it
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (character == itra_pkg::CHAR_MINUS)) |-> !last)
        else $error("minus sign flagged as final character");

endmodule

bind integer_to_radix_ascii_core itra_checker u_itra_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (number.valid),
    .in_ready    (number.ready),
    .out_valid   (text.valid),
    .out_ready   (text.ready),
    .character   (text.character),
    .last        (text.last),
    .text_length (text.text_length)
);

### tb/integer_to_radix_ascii_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for integer_to_radix_ascii_core: directed and random values and
// radix writes, predicted characters checked in order. Uses itra_pkg, itra_if, the DUT.
module integer_to_radix_ascii_core_test;

    // Expected text for every accepted number request, kept in arrival order.
    class text_scoreboard;
        logic [itra_pkg::RADIX_W-1:0] radix_reg;
        itra_pkg::text_item_t         expected_chars[$];
        int unsigned                  errors;

        function new();
            radix_reg = itra_pkg::RADIX_RESET;
            errors    = 0;
        endfunction

        function void set_radix(logic [itra_pkg::RADIX_W-1:0] r);
            radix_reg = r;
        endfunction

        // Saturate the raw register into 2..36
        function int unsigned effective_radix();
            int unsigned b;
            b = 32'(radix_reg);
            if (b < 2)
                b = 2;
            else if (b > 36)
                b = 36;
            return b;
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        function void note_value(itra_pkg::value_t v);
            int unsigned                  b;
            logic                         neg;
            logic [itra_pkg::VALUE_W-1:0] magnitude;
            logic [itra_pkg::DIGIT_W-1:0] digits[itra_pkg::MAX_DIGITS];
            int                           n_digits;
            int                           total;
            itra_pkg::text_item_t         item;
            b = effective_radix();
            neg = (b == 10) && v[itra_pkg::VALUE_W-1];
            magnitude = v;
            if (neg)
                magnitude = -magnitude;
            n_digits = 0;
            do
            begin
                digits[n_digits] = itra_pkg::DIGIT_W'(magnitude % b);
                magnitude = magnitude / b;
                n_digits++;
            end
            while (magnitude != 0 && n_digits < itra_pkg::MAX_DIGITS);
            total = n_digits + (neg ? 1 : 0);
            if (neg)
            begin
                item.character   = itra_pkg::CHAR_MINUS;
                item.last        = 1'b0;
                item.text_length = '0;
                expected_chars.push_back(item);
            end
            for (int k = n_digits - 1; k >= 0; k--)
            begin
                if (digits[k] < 10)
                    item.character = itra_pkg::CHAR_ZERO + itra_pkg::CHAR_W'(digits[k]);
                else
                    item.character = itra_pkg::CHAR_A + itra_pkg::CHAR_W'(digits[k] - 10);
                item.last        = (k == 0);
                item.text_length = (k == 0) ? itra_pkg::LEN_W'(total) : '0;
                expected_chars.push_back(item);
            end
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("%0t ns: %s", $time, what);
        endtask

        task check_char(logic [itra_pkg::CHAR_W-1:0] c, logic l,
                        logic [itra_pkg::LEN_W-1:0] len);
            itra_pkg::text_item_t want;
            if (expected_chars.size() == 0)
            begin
                report_mismatch($sformatf("unexpected character 0x%02h", c));
                return;
            end
            want = expected_chars.pop_front();
            if (c !== want.character)
                report_mismatch($sformatf("character 0x%02h, wanted 0x%02h",
                                          c, want.character));
            if (l !== want.last)
                report_mismatch($sformatf("last %b, wanted %b (char 0x%02h)",
                                          l, want.last, want.character));
            if (len !== want.text_length)
                report_mismatch($sformatf("text_length %0d, wanted %0d",
                                          len, want.text_length));
        endtask
    endclass

    // Worst item: 32 binary digits, each a full division, plus 32 characters, each
    // character possibly held by receiver stalls; then taken three times over.
    localparam int RANDOM_PHASES   = 15;
    localparam int PHASE_ITEMS     = 30;
    localparam int CALM_PHASES     = 2;
    localparam int WORST_ITEM      = 1500;
    localparam int CYCLE_LIMIT     = 3 * (RANDOM_PHASES * PHASE_ITEMS + 30) * WORST_ITEM;

    logic clk;
    logic rst_n;

    itra_value_if number_ch ();
    itra_text_if  text_ch ();
    itra_cfg_if   cfg_ch ();

    integer_to_radix_ascii_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number_ch),
        .text   (text_ch),
        .cfg    (cfg_ch)
    );

    text_scoreboard sb = new();

    // Idle chances in percent per offered request or receiver cycle, changed per phase
    int unsigned send_idle_pct;
    int unsigned ready_idle_pct;
    int unsigned cycle_count;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Give up on a hung block
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("integer_to_radix_ascii_core_test NOT OK");
            $finish;
        end
    end

    // Receiver: hold ready low for random bursts, otherwise take every character
    initial
    begin
        text_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (ready_idle_pct != 0 && $urandom_range(0, 99) < ready_idle_pct)
            begin
                text_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            text_ch.ready <= 1'b1;
        end
    end

    // Check every accepted text request against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && text_ch.valid && text_ch.ready)
            sb.check_char(text_ch.character, text_ch.last, text_ch.text_length);
    end

    // Offer one number request; valid is left high so back-to-back requests need no
    // second assignment in the acceptance step.
    task send_value(itra_pkg::value_t v);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            number_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        number_ch.valid <= 1'b1;
        number_ch.value <= v;
        do
            @(posedge clk);
        while (!number_ch.ready);
        sb.note_value(v);
    endtask

    // Drop valid and wait until every predicted character has come out
    task drain_text();
        number_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Write the radix; call only while the block is idle
    task write_radix(logic [itra_pkg::RADIX_W-1:0] r);
        cfg_ch.valid <= 1'b1;
        cfg_ch.radix <= r;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.set_radix(r);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mix of full-range, small, negative, extreme and radix-boundary values
    function itra_pkg::value_t random_value(int unsigned b);
        longint           p;
        itra_pkg::value_t v;
        case ($urandom_range(0, 7))
            0: v = $urandom;
            1: v = $urandom_range(0, 40);
            2: v = -$signed({1'b0, 31'($urandom_range(1, 40))});
            3:
            begin
                case ($urandom_range(0, 4))
                    0: v = 0;
                    1: v = 1;
                    2: v = -1;
                    3: v = 32'sh7FFF_FFFF;
                    default: v = 32'sh8000_0000;
                endcase
            end
            4, 5:
            begin
                // Hit the digit count boundary: a power of the radix or one below it
                p = 1;
                repeat ($urandom_range(1, 32))
                    if (p * b <= 64'hFFFF_FFFF)
                        p = p * b;
                v = itra_pkg::value_t'(p - $urandom_range(0, 1));
            end
            6: v = $urandom | 32'h8000_0000;
            default: v = $urandom >> $urandom_range(0, 31);
        endcase
        return v;
    endfunction

    initial
    begin
        logic [itra_pkg::RADIX_W-1:0] r;

        rst_n           <= 1'b0;
        number_ch.valid <= 1'b0;
        number_ch.value <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.radix    <= '0;
        cycle_count     <= 0;
        send_idle_pct    = 20;
        ready_idle_pct   = 20;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: decimal with the reset radix, sign handling and the most
        // negative value, then radixes 2, 16 and 36 and every saturation of the radix register.
        send_value(0);
        send_value(1);
        send_value(-1);
        send_value(9);
        send_value(10);
        send_value(-10);
        send_value(32'sh7FFF_FFFF);
        send_value(32'sh8000_0000);
        send_value(123456789);
        drain_text();
        write_radix(itra_pkg::RADIX_W'(2));
        send_value(0);
        send_value(-1);
        send_value(32'sh8000_0000);
        drain_text();
        write_radix(itra_pkg::RADIX_W'(16));
        send_value(32'shDEAD_BEEF);
        send_value(255);
        drain_text();
        write_radix(itra_pkg::RADIX_W'(36));
        send_value(35);
        send_value(36);
        send_value(-1);
        drain_text();
        write_radix(itra_pkg::RADIX_W'(0));
        send_value(5);
        drain_text();
        write_radix(itra_pkg::RADIX_W'(1));
        send_value(6);
        drain_text();
        write_radix(itra_pkg::RADIX_W'(37));
        send_value(35);
        drain_text();
        write_radix(itra_pkg::RADIX_W'(63));
        send_value(1295);
        send_value(-1);
        drain_text();

        // Random phases, each with its own radix and idle pattern; the last ones
        // and every third one run without any idling.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: r = itra_pkg::RADIX_DEC;
                1: r = itra_pkg::RADIX_MIN;
                2: r = itra_pkg::RADIX_W'(16);
                default:
                    if ($urandom_range(0, 4) == 0)
                        r = itra_pkg::RADIX_W'($urandom_range(0, 63));
                    else
                        r = itra_pkg::RADIX_W'($urandom_range(2, 36));
            endcase
            write_radix(r);
            if (ph >= RANDOM_PHASES - CALM_PHASES || ph % 3 == 0)
            begin
                send_idle_pct  = 0;
                ready_idle_pct = 0;
            end
            else
            begin
                send_idle_pct  = $urandom_range(10, 50);
                ready_idle_pct = $urandom_range(10, 50);
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_value(random_value(sb.effective_radix()));
            drain_text();
        end

        // Watch for stray characters a while longer
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("integer_to_radix_ascii_core_test OK");
        else
            $display("integer_to_radix_ascii_core_test NOT OK");
        $finish;
    end
endmodule
